>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the Base64 stream decoder
// Result kinds, queue entry layout and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [7:0] PAD_CHAR  = 8'h3D;  // '='
	localparam logic [7:0] NUL_CHAR  = 8'h00;
	localparam logic [7:0] PLUS_CHAR = 8'h2B;  // '+'
	localparam logic [7:0] SLASH_CHAR = 8'h2F; // '/'

	localparam logic [6:0] SYM_PLUS_VAL  = 7'd62;
	localparam logic [6:0] SYM_SLASH_VAL = 7'd63;
	localparam logic [6:0] SYM_INVALID   = 7'd64;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// One accepted word's worth of results: optional data byte, optional end mark.
	typedef struct packed {
		logic       has_data;
		logic [7:0] data;
		logic       has_end;
		logic       end_err;
	} entry_t;

	// Alphabet value 0..63, SYM_INVALID for anything outside the alphabet.
	function automatic logic [6:0] sym_value(input logic [7:0] c);
		logic [7:0] v;
		v = {1'b0, SYM_INVALID};
		if (c inside {[8'h41:8'h5A]}) begin
			v = c - 8'd65;
		end else if (c inside {[8'h61:8'h7A]}) begin
			v = c - 8'd71;
		end else if (c inside {[8'h30:8'h39]}) begin
			v = c + 8'd4;
		end else if (c == PLUS_CHAR) begin
			v = {1'b0, SYM_PLUS_VAL};
		end else if (c == SLASH_CHAR) begin
			v = {1'b0, SYM_SLASH_VAL};
		end
		return v[6:0];
	endfunction

endpackage

>>> hw/rtl/b64d_in_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if: character channel
// valid/ready channel carrying one raw character and its frame end mark.
// ----------------------------------------------------------------------------
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

>>> hw/rtl/b64d_out_if.sv
// ----------------------------------------------------------------------------
// b64d_out_if: result channel
// valid/ready channel carrying decoded bytes and end-of-message marks.
// ----------------------------------------------------------------------------
interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic       out_last;

	modport source (output valid, output out_byte, output out_kind, output out_last,
		input ready);
	modport sink   (input valid, input out_byte, input out_kind, input out_last,
		output ready);
endinterface

>>> hw/rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: framed Base64 (standard alphabet) decoder
// One character word in per cycle while the queue is not full, decoded bytes and end marks out.
// ----------------------------------------------------------------------------
// Usage:
//   din  carries one character per word plus in_last on a frame's final
//        character. Whitespace, non-alphabet bytes and bytes >= 128 are
//        skipped; a zero character stops decoding for the rest of the frame.
//   dout carries results: kind data (out_byte valid), then on in_last an end
//        word of kind ok or error. On error, drop the frame's bytes.
//        out_last marks the last result caused by one character.
// Path: an accepted character is written into the queue, and the output
//   register is loaded from the queue head to drive dout.
// Throughput: one character per cycle while the queue is not full. A final
//   character that also yields a data byte produces two results and holds
//   the output stage for both. The 4-entry queue between classifier and
//   output soaks that up.
// Reset (arst_n low): decoder state clears, queue empties, dout.valid drops.
// Stall: while dout.ready is low the output word holds, the queue fills, and
//   din.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	b64d_in_if.sink     din,
	b64d_out_if.source  dout
);

	b64d_pkg::entry_t push_entry;
	b64d_pkg::entry_t head;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;

	// classify characters and run the 6-to-8 bit accumulator
	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (din),
		.full   (full),
		.push   (push),
		.entry  (push_entry)
	);

	// decoupling queue: one entry per character that yields any result
	b64d_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	// split entries into output words
	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.tx     (dout)
	);

endmodule

>>> hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: character classifier and bit accumulator
// Accepts one character per cycle while the queue is not full, tracks padding
// and termination, and pushes the word's results into the queue.
// ----------------------------------------------------------------------------
module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	b64d_in_if.sink           rx,
	input  logic              full,
	output logic              push,
	output b64d_pkg::entry_t  entry
);

	logic [1:0] phase_q;
	logic [7:0] partial_q;
	logic       pad_q;
	logic       term_q;
	logic       failed_q;

	logic [6:0] sym;
	logic [5:0] v;
	logic       is_pad;
	logic       active;
	logic       fail_now;
	logic       active2;
	logic       is_sym;
	logic       pad_n;
	logic       term_n;
	logic       failed_n;
	logic [7:0] data;
	logic [7:0] partial_n;
	logic       accept;

	always_comb begin
		sym      = b64d_pkg::sym_value(rx.in_char);
		v        = sym[5:0];
		is_pad   = (rx.in_char == b64d_pkg::PAD_CHAR);
		active   = !term_q && !failed_q;
		// a pending '=' must be followed by another '='
		fail_now = active && pad_q && !is_pad;
		active2  = active && !fail_now;
		is_sym   = active2 && (sym != b64d_pkg::SYM_INVALID);
		pad_n    = active2 && is_pad && (phase_q == 2'd1);
		term_n   = term_q || (active2 && (rx.in_char == b64d_pkg::NUL_CHAR));
		failed_n = failed_q || fail_now;

		data      = 8'd0;
		partial_n = partial_q;
		case (phase_q)
			2'd0: begin
				partial_n = {v, 2'b00};
			end
			2'd1: begin
				data      = partial_q | {6'd0, v[5:4]};
				partial_n = {v[3:0], 4'd0};
			end
			2'd2: begin
				data      = partial_q | {4'd0, v[5:2]};
				partial_n = {v[1:0], 6'd0};
			end
			default: begin
				data      = partial_q | {2'd0, v};
			end
		endcase

		entry.has_data = is_sym && (phase_q != 2'd0);
		entry.data     = data;
		entry.has_end  = rx.in_last;
		entry.end_err  = failed_n || pad_n;

		rx.ready = !full;
		accept   = rx.valid && !full;
		push     = accept && (entry.has_data || entry.has_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			partial_q <= 8'd0;
			pad_q     <= 1'b0;
			term_q    <= 1'b0;
			failed_q  <= 1'b0;
		end else if (accept) begin
			if (rx.in_last) begin
				phase_q   <= 2'd0;
				partial_q <= 8'd0;
				pad_q     <= 1'b0;
				term_q    <= 1'b0;
				failed_q  <= 1'b0;
			end else begin
				pad_q    <= pad_n;
				term_q   <= term_n;
				failed_q <= failed_n;
				if (is_sym) begin
					phase_q   <= phase_q + 2'd1;
					partial_q <= partial_n;
				end
			end
		end
	end

endmodule

>>> hw/rtl/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo: result queue
// Short register queue decoupling the classifier from the output stage.
// ----------------------------------------------------------------------------
module b64d_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64d_pkg::entry_t  wdata,
	input  logic              pop,
	output b64d_pkg::entry_t  head,
	output logic              full,
	output logic              empty
);

	b64d_pkg::entry_t mem_q [b64d_pkg::FIFO_DEPTH];

	logic [b64d_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [b64d_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [b64d_pkg::FIFO_CW-1:0] count_q;
	logic                         do_push;
	logic                         do_pop;

	always_comb begin
		full    = (count_q == b64d_pkg::FIFO_CW'(b64d_pkg::FIFO_DEPTH));
		empty   = (count_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		head    = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == b64d_pkg::FIFO_AW'(b64d_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == b64d_pkg::FIFO_AW'(b64d_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: output stage
// Unpacks queue entries into result words, data byte before end mark.
// ----------------------------------------------------------------------------
module b64d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64d_pkg::entry_t  head,
	input  logic              empty,
	output logic              pop,
	b64d_out_if.source        tx
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic       pend_q;      // end mark still owed after a data byte
	logic       pend_err_q;
	logic       slot_free;

	always_comb begin
		slot_free   = !valid_q || tx.ready;
		pop         = slot_free && !pend_q && !empty;
		tx.valid    = valid_q;
		tx.out_byte = byte_q;
		tx.out_kind = kind_q;
		tx.out_last = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			kind_q     <= b64d_pkg::KIND_DATA;
			last_q     <= 1'b0;
			pend_q     <= 1'b0;
			pend_err_q <= 1'b0;
		end else if (slot_free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				kind_q  <= pend_err_q ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
				last_q  <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!empty) begin
				valid_q <= 1'b1;
				if (head.has_data) begin
					kind_q     <= b64d_pkg::KIND_DATA;
					last_q     <= !head.has_end;
					pend_q     <= head.has_end;
					pend_err_q <= head.end_err;
				end else begin
					kind_q <= head.end_err ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
					last_q <= 1'b1;
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (pend_q || !head.has_data) begin
				byte_q <= 8'd0;
			end else begin
				byte_q <= head.data;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (kind_q != b64d_pkg::KIND_DATA) |-> last_q)
		else $error("end mark not flagged last");

	a_pend_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> valid_q && (kind_q == b64d_pkg::KIND_DATA) && !last_q)
		else $error("owed end mark without a data byte in front");

	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (kind_q == b64d_pkg::KIND_DATA) && !last_q |-> pend_q)
		else $error("non-last data byte without an owed end mark");

	a_no_pop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !pop)
		else $error("queue popped while an end mark is owed");
`endif

endmodule
